/* rtl/core/simple_moving_average_assert.svh */
// Assertion macros shared by the moving average modules.
// Each expects i_clk and i_rst_n in scope.
`ifndef SIMPLE_MOVING_AVERAGE_ASSERT_SVH
`define SIMPLE_MOVING_AVERAGE_ASSERT_SVH

// Same-cycle implication.
`define SMA_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/sma_pkg.sv */
package sma_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int MAX_WINDOW  = 64;
    localparam int CFG_BITS    = 7;
    localparam int WIN_RESET   = 3;
    localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
    localparam int WIN_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS    = SAMPLE_BITS + SLOT_BITS;
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [SUM_BITS-1:0] sum;
        logic [WIN_BITS-1:0] len;
        logic                full;
    } t_job;

    function automatic logic [WIN_BITS-1:0] eff_window(input logic [CFG_BITS-1:0] len);
        logic [WIN_BITS-1:0] n;
        if (len == '0) begin
            n = WIN_BITS'(1);
        end else if (len > CFG_BITS'(MAX_WINDOW)) begin
            n = WIN_BITS'(MAX_WINDOW);
        end else begin
            n = WIN_BITS'(len);
        end
        return n;
    endfunction

endpackage

/* rtl/core/sma_if.sv */
interface sma_in_if;
    import sma_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface sma_out_if;
    import sma_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] average;
    logic                   ready_res;

    modport source (output valid, output average, output ready_res, input ready);
    modport sink   (input valid, input average, input ready_res, output ready);
endinterface

/* rtl/core/sma_front.sv */
`include "simple_moving_average_assert.svh"

module sma_front
    import sma_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_BITS-1:0] i_cfg_wr_data,
    sma_in_if.sink              i_in,
    input  logic                i_q_full,
    output logic                o_push,
    output t_job                o_job
);

    typedef enum logic {ST_IDLE, ST_UPD} t_state;

    t_state                 r_state;
    logic [CFG_BITS-1:0]    r_window;
    logic [SLOT_BITS-1:0]   r_slot;
    logic [WIN_BITS-1:0]    r_fill;
    logic [SUM_BITS-1:0]    r_sum;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [SAMPLE_BITS-1:0] r_old;
    logic [SAMPLE_BITS-1:0] r_hist [MAX_WINDOW];

    logic [WIN_BITS-1:0]    w_n;
    logic                   w_full_before;
    logic                   w_accept;
    logic [SAMPLE_BITS-1:0] w_drop;
    logic [WIN_BITS-1:0]    w_slot_inc;
    logic [SUM_BITS-1:0]    n_sum;
    logic [WIN_BITS-1:0]    n_fill;
    logic [SLOT_BITS-1:0]   n_slot;

    always_comb begin
        w_n           = eff_window(r_window);
        w_full_before = (r_fill >= w_n);
        w_accept      = i_in.valid && i_in.ready;
        w_drop        = w_full_before ? r_old : '0;
        n_sum         = r_sum - SUM_BITS'(w_drop) + SUM_BITS'(r_sample);
        n_fill        = w_full_before ? r_fill : r_fill + WIN_BITS'(1);
        w_slot_inc    = WIN_BITS'(r_slot) + WIN_BITS'(1);
        n_slot        = (w_slot_inc >= w_n) ? '0 : w_slot_inc[SLOT_BITS-1:0];
    end

    assign i_in.ready = (r_state == ST_IDLE);
    assign o_push     = (r_state == ST_UPD) && !i_q_full;
    assign o_job.sum  = n_sum;
    assign o_job.len  = w_n;
    assign o_job.full = (n_fill >= w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_window <= CFG_BITS'(WIN_RESET);
            r_slot   <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_sample <= i_in.sample;
                        r_state  <= ST_UPD;
                    end
                end
                ST_UPD: begin
                    if (o_push) begin
                        r_sum   <= n_sum;
                        r_fill  <= n_fill;
                        r_slot  <= n_slot;
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
            // clear history on window write
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
                r_slot   <= '0;
                r_fill   <= '0;
                r_sum    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_old <= r_hist[r_slot];
        end
        if (o_push) begin
            r_hist[r_slot] <= r_sample;
        end
    end

    `SMA_ASSERT_IMPL(a_slot_in_window, 1'b1, WIN_BITS'(r_slot) < w_n, "write slot outside window")
    `SMA_ASSERT_IMPL(a_fill_bounded, 1'b1, r_fill <= w_n, "fill count above window")
    `SMA_ASSERT_NEXT(a_push_leaves_upd, o_push, r_state == ST_IDLE, "front did not return to idle")

endmodule

/* rtl/core/sma_queue.sv */
module sma_queue
    import sma_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_push_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_pop_data,
    output logic o_empty
);

    t_job                 r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;

    function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
        logic [QPTR_BITS-1:0] r;
        r = (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
        return r;
    endfunction

    assign o_full     = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_push_data;
                r_wr_ptr        <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_BITS'(1);
                2'b01:   r_count <= r_count - QCNT_BITS'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* rtl/core/sma_back.sv */
`include "simple_moving_average_assert.svh"

module sma_back
    import sma_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_empty,
    input  t_job     i_q_data,
    output logic     o_pop,
    sma_out_if.source o_out
);

    typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} t_state;

    t_state                  r_state;
    logic [WIN_BITS-1:0]     r_rem;
    logic [WIN_BITS-1:0]     r_div;
    logic [SUM_BITS-1:0]     r_quo;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_full;
    logic                    r_out_valid;
    logic [SAMPLE_BITS-1:0]  r_out_avg;
    logic                    r_out_rdy;

    logic [WIN_BITS:0]       w_rem_sh;
    logic                    w_ge;
    logic [WIN_BITS:0]       w_rem_nx;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[SUM_BITS-1]};
        w_ge     = (w_rem_sh >= {1'b0, r_div});
        w_rem_nx = w_ge ? (w_rem_sh - {1'b0, r_div}) : w_rem_sh;
    end

    assign o_pop           = (r_state == ST_IDLE) && !i_q_empty;
    assign o_out.valid     = r_out_valid;
    assign o_out.average   = r_out_avg;
    assign o_out.ready_res = r_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_div   <= i_q_data.len;
                        r_rem   <= '0;
                        r_cnt   <= DIV_CNT_BITS'(SUM_BITS);
                        r_full  <= i_q_data.full;
                        r_quo   <= i_q_data.full ? i_q_data.sum : '0;
                        r_state <= i_q_data.full ? ST_DIV : ST_DONE;
                    end
                end
                ST_DIV: begin
                    r_rem <= w_rem_nx[WIN_BITS-1:0];
                    r_quo <= {r_quo[SUM_BITS-2:0], w_ge};
                    r_cnt <= r_cnt - DIV_CNT_BITS'(1);
                    if (r_cnt == DIV_CNT_BITS'(1)) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_out_avg   <= r_quo[SAMPLE_BITS-1:0];
                        r_out_rdy   <= r_full;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `SMA_ASSERT_IMPL(a_rem_below_div, r_state == ST_DIV, r_rem < r_div, "remainder not below divisor")
    `SMA_ASSERT_IMPL(a_not_full_zero, r_out_valid && !r_out_rdy, r_out_avg == '0, "average not zero before window full")
    `SMA_ASSERT_NEXT(a_div_ends, (r_state == ST_DIV) && (r_cnt == DIV_CNT_BITS'(1)), r_state == ST_DONE, "divider did not finish")

endmodule

/* rtl/core/simple_moving_average.sv */
// Once the window is full, each result passes the front update, the queue and the bit-serial
// divider; before that the divider is skipped and the average is zero (no division needed).
// The divider makes one quotient bit per cycle over the 38-bit sum and takes a new job only
// when done; the front takes no new sample until its last job enters the 2-entry queue.
// Reset is synchronous, active low: window length 3, history, sum and fill count empty.
module simple_moving_average
    import sma_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_BITS-1:0] i_cfg_wr_data,
    sma_in_if.sink              i_in,
    sma_out_if.source           o_out
);

    logic w_push;
    logic w_pop;
    logic w_q_full;
    logic w_q_empty;
    t_job w_push_job;
    t_job w_pop_job;

    sma_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .i_q_full      (w_q_full),
        .o_push        (w_push),
        .o_job         (w_push_job)
    );

    sma_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_job),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_job),
        .o_empty     (w_q_empty)
    );

    sma_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_pop_job),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import sma_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int SETTLE_TIME  = 60;
    localparam int LONG_HOLD    = 400;
    localparam int N_PHASES     = 10;
    localparam int PHASE_RANDOM = -1;

    typedef struct {
        logic [SAMPLE_BITS-1:0] average;
        logic                   ready_res;
    } t_avg_result;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [CFG_BITS-1:0] cfg_wr_data = '0;

    sma_in_if  smp_if ();
    sma_out_if avg_if ();

    simple_moving_average dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (smp_if),
        .o_out         (avg_if)
    );

    always #1 i_clk = ~i_clk;

    logic [SAMPLE_BITS-1:0] sample_q [$];
    t_avg_result            avg_expect_q [$];

    logic [SAMPLE_BITS-1:0] ring [MAX_WINDOW];
    int unsigned            ring_slot;
    int unsigned            ring_fill;
    logic [SUM_BITS-1:0]    ring_sum;
    logic [CFG_BITS-1:0]    win_cfg;

    int mismatches  = 0;
    int cycle_count = 0;
    int stall_pct   = 0;
    bit sender_gaps = 1'b0;
    int holds_asked = 0;
    int holds_done  = 0;

    function automatic void clear_window();
        ring_slot = 0;
        ring_fill = 0;
        ring_sum  = '0;
    endfunction

    function automatic void predict_average(input logic [SAMPLE_BITS-1:0] s);
        int unsigned span;
        int unsigned slot;
        t_avg_result r;
        span = (win_cfg == 0) ? 1 : ((win_cfg > MAX_WINDOW) ? MAX_WINDOW : int'(win_cfg));
        slot = (ring_slot >= span) ? 0 : ring_slot;
        if (ring_fill >= span) begin
            ring_sum = ring_sum - SUM_BITS'(ring[slot]);
        end else begin
            ring_fill++;
        end
        ring[slot] = s;
        ring_sum   = ring_sum + SUM_BITS'(s);
        slot++;
        ring_slot = (slot >= span) ? 0 : slot;
        if (ring_fill >= span) begin
            r.average   = SAMPLE_BITS'(ring_sum / SUM_BITS'(span));
            r.ready_res = 1'b1;
        end else begin
            r.average   = '0;
            r.ready_res = 1'b0;
        end
        avg_expect_q.push_back(r);
    endfunction

    function automatic void flag_mismatch(input string what, input t_avg_result want,
                                          input logic [SAMPLE_BITS-1:0] got_avg,
                                          input logic got_rdy);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t %s: expected average %h ready_res %b, got average %h ready_res %b",
                     $realtime, what, want.average, want.ready_res, got_avg, got_rdy);
        end
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_BITS'($urandom_range(0, 255));
            3: return {8'($urandom_range(0, 255)), 24'hFFFFFF};
            default: return $urandom;
        endcase
    endfunction

    // model: track config writes and accepted samples
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_window();
            win_cfg = CFG_BITS'(WIN_RESET);
        end else begin
            if (cfg_wr_en) begin
                win_cfg = cfg_wr_data;
                clear_window();
            end
            if (smp_if.valid && smp_if.ready) begin
                predict_average(smp_if.sample);
            end
        end
    end

    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid  <= 1'b0;
            smp_if.sample <= '0;
        end else if (!smp_if.valid || smp_if.ready) begin
            if (smp_if.valid) begin
                void'(sample_q.pop_front());
                burst_left--;
            end
            if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left   = sender_gaps ? $urandom_range(1, 12) : 0;
            end
            if (gap_left > 0) begin
                gap_left--;
                smp_if.valid <= 1'b0;
            end else if (sample_q.size() != 0) begin
                smp_if.valid  <= 1'b1;
                smp_if.sample <= sample_q[0];
            end else begin
                smp_if.valid <= 1'b0;
            end
        end
    end

    int run_left  = 0;
    int hold_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            avg_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            avg_if.ready <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD - 1;
            avg_if.ready <= 1'b0;
        end else if (run_left > 0) begin
            run_left--;
        end else begin
            run_left = $urandom_range(0, 15);
            avg_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_avg_result want;
        if (i_rst_n && avg_if.valid && avg_if.ready) begin
            if (avg_expect_q.size() == 0) begin
                want.average   = '0;
                want.ready_res = 1'b0;
                flag_mismatch("result with none pending", want, avg_if.average,
                              avg_if.ready_res);
            end else begin
                want = avg_expect_q.pop_front();
                if (avg_if.average !== want.average || avg_if.ready_res !== want.ready_res) begin
                    flag_mismatch("result mismatch", want, avg_if.average, avg_if.ready_res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_window(input logic [CFG_BITS-1:0] value);
        @(posedge i_clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || smp_if.valid || avg_expect_q.size() != 0);
    endtask

    initial begin
        int phase_cfg [N_PHASES];
        int cfg_value;
        int n_items;
        phase_cfg = '{64, 127, 1, 2, 65, PHASE_RANDOM, PHASE_RANDOM, 3, PHASE_RANDOM, 100};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sample_q = {32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                    32'h0, 32'h0, 32'h0, 32'h1, 32'h2, 32'h3,
                    32'h80000000, 32'h7FFFFFFF, 32'h55555555, 32'hAAAAAAAA,
                    32'h00010000, 32'hFFFF0000};
        wait_drained();

        write_window('0);
        sample_q = {32'hFFFFFFFF, 32'h1, 32'h0};
        wait_drained();

        for (int p = 0; p < N_PHASES; p++) begin
            stall_pct   = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 30 : 70);
            sender_gaps = (p % 2 == 1);
            cfg_value   = (phase_cfg[p] == PHASE_RANDOM) ? $urandom_range(0, 127)
                                                         : phase_cfg[p];
            write_window(CFG_BITS'(cfg_value));
            n_items = (cfg_value >= 32) ? 75 : 20;
            for (int i = 0; i < n_items; i++) begin
                sample_q.push_back(rand_sample());
                // pause mid-window until every result is back
                if (p == 0 && i == n_items / 2) begin
                    wait_drained();
                end
            end
            if (phase_cfg[p] == 2) begin
                holds_asked++;
            end
            wait_drained();
        end

        repeat (SETTLE_TIME) @(posedge i_clk);
        if (mismatches == 0 && avg_expect_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
